// ----- rtl/tion_pkg.sv -----
// Package for the telnet option negotiator: payload and job types, telnet
// byte codes, command and phase codes, and the hello offer table.
// No dependencies.
package tion_pkg;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] slot;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [1:0] out_slot;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  localparam logic [1:0] JOB_KEY   = 2'd0;
  localparam logic [1:0] JOB_REPLY = 2'd1;
  localparam logic [1:0] JOB_HELLO = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] slot;
    logic [7:0] b0;
    logic [7:0] b1;
  } job_t;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_DONT = 8'd254;

  localparam logic [7:0] BINARY_OPTION = 8'd0;
  localparam logic [7:0] ECHO_OPTION   = 8'd1;
  localparam logic [7:0] SGA_OPTION    = 8'd3;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_HELLO = 2'd2;

  localparam logic [2:0] PH_DATA   = 3'd0;
  localparam logic [2:0] PH_IAC    = 3'd1;
  localparam logic [2:0] PH_VERB   = 3'd2;
  localparam logic [2:0] PH_SB     = 3'd3;
  localparam logic [2:0] PH_SB_IAC = 3'd4;

  localparam logic [3:0] HELLO_WILL = 4'b1011;
  localparam logic [3:0] HELLO_DO   = 4'b1001;
  localparam logic [3:0] STEP_KEY_LAST   = 4'd0;
  localparam logic [3:0] STEP_REPLY_LAST = 4'd2;
  localparam logic [3:0] STEP_HELLO_LAST = 4'd14;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  function automatic logic [7:0] hello_byte(input logic [3:0] step);
    logic [7:0] b;
    case (step)
      4'd1:    b = B_WILL;
      4'd2:    b = ECHO_OPTION;
      4'd4:    b = B_WILL;
      4'd5:    b = SGA_OPTION;
      4'd7:    b = B_DO;
      4'd8:    b = SGA_OPTION;
      4'd10:   b = B_WILL;
      4'd11:   b = BINARY_OPTION;
      4'd13:   b = B_DO;
      4'd14:   b = BINARY_OPTION;
      default: b = B_IAC;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/tion_front.sv -----
// Front end of the telnet option negotiator: keeps per-slot parser state,
// classifies each accepted item and, where it calls for output, queues a job.
// Depends on tion_pkg.
module tion_front #(
  parameter int SLOTS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  tion_pkg::in_item_t item,
  output logic              job_push,
  output tion_pkg::job_t    job
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [2:0] phase_r [SLOTS];
  logic [2:0] phase_nxt [SLOTS];
  logic [7:0] verb_r [SLOTS];
  logic [3:0] will_r [SLOTS];
  logic [3:0] will_nxt [SLOTS];
  logic [3:0] do_r [SLOTS];
  logic [3:0] do_nxt [SLOTS];

  logic [SW-1:0] sidx;
  logic          slot_ok;
  logic [7:0]    b;
  logic [7:0]    pv;
  logic [3:0]    bitv;
  logic [2:0]    ph;
  logic          verb_we;

  assign sidx    = SW'(item.slot);
  assign slot_ok = (32'(item.slot) < SLOTS);
  assign b       = item.data_byte;
  assign pv      = verb_r[sidx];
  assign ph      = phase_r[sidx];
  assign bitv    = (b[7:2] == 6'd0) ? (4'b0001 << b[1:0]) : 4'b0000;

  always_comb begin
    phase_nxt = phase_r;
    will_nxt  = will_r;
    do_nxt    = do_r;
    verb_we   = 1'b0;
    job_push  = 1'b0;
    job.kind  = tion_pkg::JOB_KEY;
    job.slot  = item.slot;
    job.b0    = b;
    job.b1    = b;
    if (accept && slot_ok) begin
      unique case (item.cmd)
        tion_pkg::CMD_BYTE: begin
          case (ph)
            tion_pkg::PH_IAC: begin
              if (b == tion_pkg::B_IAC) begin
                job_push        = 1'b1;
                phase_nxt[sidx] = tion_pkg::PH_DATA;
              end else if (b == tion_pkg::B_SB) begin
                phase_nxt[sidx] = tion_pkg::PH_SB;
              end else if (b >= tion_pkg::B_WILL && b <= tion_pkg::B_DONT) begin
                verb_we         = 1'b1;
                phase_nxt[sidx] = tion_pkg::PH_VERB;
              end else begin
                phase_nxt[sidx] = tion_pkg::PH_DATA;
              end
            end
            tion_pkg::PH_VERB: begin
              phase_nxt[sidx] = tion_pkg::PH_DATA;
              job.kind        = tion_pkg::JOB_REPLY;
              if (pv == tion_pkg::B_DO) begin
                if (b == tion_pkg::ECHO_OPTION || b == tion_pkg::SGA_OPTION ||
                    b == tion_pkg::BINARY_OPTION) begin
                  if ((will_r[sidx] & bitv) == 4'd0) begin
                    job_push       = 1'b1;
                    job.b0         = tion_pkg::B_WILL;
                    will_nxt[sidx] = will_r[sidx] | bitv;
                  end
                end else begin
                  job_push = 1'b1;
                  job.b0   = tion_pkg::B_WONT;
                end
              end else if (pv == tion_pkg::B_WILL) begin
                if (b == tion_pkg::SGA_OPTION || b == tion_pkg::BINARY_OPTION) begin
                  if ((do_r[sidx] & bitv) == 4'd0) begin
                    job_push     = 1'b1;
                    job.b0       = tion_pkg::B_DO;
                    do_nxt[sidx] = do_r[sidx] | bitv;
                  end
                end else begin
                  job_push = 1'b1;
                  job.b0   = tion_pkg::B_DONT;
                end
              end else if (pv == tion_pkg::B_WONT) begin
                job_push = 1'b1;
                job.b0   = tion_pkg::B_DONT;
              end else if (pv == tion_pkg::B_DONT) begin
                job_push = 1'b1;
                job.b0   = tion_pkg::B_WONT;
              end
            end
            tion_pkg::PH_SB: begin
              if (b == tion_pkg::B_IAC) begin
                phase_nxt[sidx] = tion_pkg::PH_SB_IAC;
              end
            end
            tion_pkg::PH_SB_IAC: begin
              phase_nxt[sidx] = (b == tion_pkg::B_SE) ? tion_pkg::PH_DATA : tion_pkg::PH_SB;
            end
            default: begin
              if (b == tion_pkg::B_IAC) begin
                phase_nxt[sidx] = tion_pkg::PH_IAC;
              end else begin
                job_push        = 1'b1;
                phase_nxt[sidx] = tion_pkg::PH_DATA;
              end
            end
          endcase
        end
        tion_pkg::CMD_RESET: begin
          phase_nxt[sidx] = tion_pkg::PH_DATA;
          will_nxt[sidx]  = 4'd0;
          do_nxt[sidx]    = 4'd0;
        end
        tion_pkg::CMD_HELLO: begin
          job_push       = 1'b1;
          job.kind       = tion_pkg::JOB_HELLO;
          will_nxt[sidx] = tion_pkg::HELLO_WILL;
          do_nxt[sidx]   = tion_pkg::HELLO_DO;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        phase_r[i] <= tion_pkg::PH_DATA;
        will_r[i]  <= 4'd0;
        do_r[i]    <= 4'd0;
      end
    end else begin
      phase_r <= phase_nxt;
      will_r  <= will_nxt;
      do_r    <= do_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (verb_we) begin
      verb_r[sidx] <= b;
    end
  end

endmodule

// ----- rtl/tion_fifo.sv -----
// Short job queue between the front and back ends of the negotiator.
// Depends on tion_pkg.
module tion_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tion_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tion_pkg::job_t head
);

  tion_pkg::job_t mem [tion_pkg::QDEPTH];

  logic [tion_pkg::QAW-1:0] wptr_r;
  logic [tion_pkg::QAW-1:0] rptr_r;
  logic [tion_pkg::QAW:0]   count_r;

  assign full  = (count_r == (tion_pkg::QAW+1)'(tion_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/tion_back.sv -----
// Back end of the negotiator: plays out the bytes of queued jobs into the
// result register, one per cycle unless a held result stalls it.
// Depends on tion_pkg.
module tion_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  tion_pkg::job_t    q_head,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output tion_pkg::out_item_t out_item
);

  logic                busy_r;
  tion_pkg::job_t      job_r;
  logic [3:0]          step_r;
  logic                out_valid_r;
  tion_pkg::out_item_t out_r;

  logic                adv;
  logic                emit;
  logic                fin;
  logic [3:0]          last_step;
  tion_pkg::out_item_t res;

  assign adv  = !out_valid_r || out_pop;
  assign emit = busy_r && adv;

  always_comb begin
    unique case (job_r.kind)
      tion_pkg::JOB_REPLY: last_step = tion_pkg::STEP_REPLY_LAST;
      tion_pkg::JOB_HELLO: last_step = tion_pkg::STEP_HELLO_LAST;
      default:             last_step = tion_pkg::STEP_KEY_LAST;
    endcase
  end

  assign fin   = emit && (step_r == last_step);
  assign q_pop = !q_empty && (!busy_r || fin);

  always_comb begin
    res.last     = (step_r == last_step);
    res.out_kind = 1'b1;
    res.out_slot = job_r.slot;
    res.out_byte = tion_pkg::B_IAC;
    unique case (job_r.kind)
      tion_pkg::JOB_REPLY: begin
        case (step_r)
          4'd1:    res.out_byte = job_r.b0;
          4'd2:    res.out_byte = job_r.b1;
          default: res.out_byte = tion_pkg::B_IAC;
        endcase
      end
      tion_pkg::JOB_HELLO: res.out_byte = tion_pkg::hello_byte(step_r);
      default: begin
        res.out_kind = 1'b0;
        res.out_slot = 2'd0;
        res.out_byte = job_r.b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        step_r <= 4'd0;
      end else if (fin) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        step_r <= step_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- rtl/telnet_iac_option_negotiator.sv -----
// Telnet receive parser with per-slot option negotiation.
// Input side is a queue: an item transfers when in_push is high and in_full
// is low. Each item is a received byte, a slot reset or a hello for one slot.
// Result side is a queue: while out_empty is low the oldest result is on
// out_item, and it transfers when out_pop is high.
// The front end updates the slot's parser state when an item is taken and
// queues a job for it if it gives results; the back end plays each job out
// one byte a cycle while out_pop keeps up. A keystroke gives one result, a
// negotiation reply three, a hello fifteen; other items queue no job.
// An item's job passes the job queue and the back end's job register
// before its first result is written, if the back end is idle. Throughput
// is one input item per cycle while the job queue has room, and one result
// per cycle while out_pop keeps up, set by the back end's single sequencer.
// If out_pop stays low, the result register holds, the back end stops, the
// four-entry job queue fills and in_full rises.
// Synchronous reset clears all slots to plain data with empty option maps
// and empties the job queue and the result register.
module telnet_iac_option_negotiator #(
  parameter int SLOTS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  tion_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output tion_pkg::out_item_t out_item
);

  logic           accept;
  logic           job_push;
  tion_pkg::job_t job;
  logic           q_pop;
  logic           q_empty;
  tion_pkg::job_t q_head;

  assign accept = in_push && !in_full;

  tion_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_item),
    .job_push(job_push),
    .job     (job)
  );

  tion_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .push_job(job),
    .full    (in_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  tion_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

endmodule
